// ----- sv/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants of the nearest palette color search
// Field widths, request kinds and the color record used by the search datapath.
// ----------------------------------------------------------------------------
package npcs_pkg;

   // field widths
   localparam int CHAN_W    = 8;
   localparam int INDEX_W   = 10;
   localparam int DIST_W    = 18;
   localparam int COUNT_W   = 11;
   localparam int SQ_W      = 2 * CHAN_W;
   localparam int COLOR_W   = 3 * CHAN_W;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   // default palette depth and largest possible distance
   localparam int DEPTH_DEFAULT = 1024;
   localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

   // request kinds carried in tuser
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // one palette color, blue in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

endpackage

// ----- sv/npcs_ram.sv -----
// ----------------------------------------------------------------------------
// npcs_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/npcs_dist.sv -----
// ----------------------------------------------------------------------------
// npcs_dist: squared Euclidean distance unit
// Two-stage pipeline: per-channel absolute difference and square, then sum.
// ----------------------------------------------------------------------------
module npcs_dist
   import npcs_pkg::*;
#(
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ADDR_W-1:0] in_index,
   input  color_type         entry,
   input  color_type         pixel,
   output logic              out_valid,
   output logic [ADDR_W-1:0] out_index,
   output logic [DIST_W-1:0] out_distance,
   output logic              busy
);

   logic              sq_valid_ff;
   logic [ADDR_W-1:0] sq_index_ff;
   logic [SQ_W-1:0]   sq_blue_ff;
   logic [SQ_W-1:0]   sq_green_ff;
   logic [SQ_W-1:0]   sq_red_ff;
   logic              sum_valid_ff;
   logic [ADDR_W-1:0] sum_index_ff;
   logic [DIST_W-1:0] sum_ff;

   logic [CHAN_W-1:0] diff_blue;
   logic [CHAN_W-1:0] diff_green;
   logic [CHAN_W-1:0] diff_red;

   // absolute channel differences
   assign diff_blue  = (entry.blue >= pixel.blue) ? (entry.blue - pixel.blue)
                                                  : (pixel.blue - entry.blue);
   assign diff_green = (entry.green >= pixel.green) ? (entry.green - pixel.green)
                                                    : (pixel.green - entry.green);
   assign diff_red   = (entry.red >= pixel.red) ? (entry.red - pixel.red)
                                                : (pixel.red - entry.red);

   // square each difference, then add the three squares
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= in_valid;
         sum_valid_ff <= sq_valid_ff;
      end
      sq_index_ff  <= in_index;
      sq_blue_ff   <= SQ_W'(diff_blue) * SQ_W'(diff_blue);
      sq_green_ff  <= SQ_W'(diff_green) * SQ_W'(diff_green);
      sq_red_ff    <= SQ_W'(diff_red) * SQ_W'(diff_red);
      sum_index_ff <= sq_index_ff;
      sum_ff       <= DIST_W'(sq_blue_ff) + DIST_W'(sq_green_ff) + DIST_W'(sq_red_ff);
   end

   assign out_valid    = sum_valid_ff;
   assign out_index    = sum_index_ff;
   assign out_distance = sum_ff;
   assign busy         = sq_valid_ff | sum_valid_ff;

endmodule

// ----- sv/nearest_palette_color_search_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit: nearest palette color by squared distance
// Loads palette entries and answers queries with the first closest entry.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   tuser kind, tdata slot and BGR
//  rsp_     out        rsp_tvalid/rsp_tready   tuser found, tdata index, distance
//  csr_     in         csr_valid/csr_ready     csr_data palette count
//
//  A load writes its slot when accepted. A query over n = min(palette_count,
//  PALETTE_DEPTH) entries reads them through the single memory read port into
//  one distance unit, one entry per cycle, and raises its response once the
//  pipeline has drained; the request side is ready again in that same cycle.
//  An empty palette skips the scan and goes straight to the drain.
//  Reset clears the count and the control state; palette contents stay undefined.
//  A response not taken holds the next query at its end, and no load passes then.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // entry_index, blue_in, green_in, red_in
   input  logic                   req_tuser,  // req_type
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // best_index, best_distance
   output logic                   rsp_tuser,  // found
   // palette count register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_W-1:0]     csr_data
);

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   color_type         pix_ff, pix_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0] rd_index_ff, rd_index_in;
   logic              have_ff, have_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_found_ff, rsp_found_in;

   logic [INDEX_W-1:0] req_entry;
   color_type          req_color;
   logic               req_fire;
   logic               wr_en;
   logic [CNT_W-1:0]   sat_count;
   logic [CNT_W-1:0]   cnt_next;
   logic [COLOR_W-1:0] rd_data;
   logic               dist_valid;
   logic [ADDR_W-1:0]  dist_index;
   logic [DIST_W-1:0]  dist_value;
   logic               dist_busy;

   // unpack request payload
   assign req_entry       = req_tdata[INDEX_W-1:0];
   assign req_color.blue  = req_tdata[INDEX_W+CHAN_W-1:INDEX_W];
   assign req_color.green = req_tdata[INDEX_W+2*CHAN_W-1:INDEX_W+CHAN_W];
   assign req_color.red   = req_tdata[INDEX_W+3*CHAN_W-1:INDEX_W+2*CHAN_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // write a palette slot only when it lies inside the store
   assign wr_en = req_fire && (req_kind_type'(req_tuser) == REQ_LOAD)
                  && (CMP_W'(req_entry) < CMP_W'(PALETTE_DEPTH));

   // clip the searched count to the store depth
   assign sat_count = (CMP_W'(count_ff) > CMP_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                                 : CNT_W'(count_ff);
   assign cnt_next  = CNT_W'(cnt_ff + 1'b1);

   npcs_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry)),
      .wr_data (req_color),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   npcs_dist #(
      .ADDR_W (ADDR_W)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (rd_valid_ff),
      .in_index     (rd_index_ff),
      .entry        (color_type'(rd_data)),
      .pixel        (pix_ff),
      .out_valid    (dist_valid),
      .out_index    (dist_index),
      .out_distance (dist_value),
      .busy         (dist_busy)
   );

   // sequencer, best-so-far tracking and response register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      pix_in       = pix_ff;
      rd_valid_in  = 1'b0;
      rd_index_in  = rd_index_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_found_in = rsp_found_ff;

      // take a new palette count
      if (csr_valid) begin
         count_in = csr_data;
      end

      // drop a response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // keep the first entry with the smallest distance
      if (dist_valid && (!have_ff || (dist_value < best_dist_ff))) begin
         have_in      = 1'b1;
         best_idx_in  = dist_index;
         best_dist_in = dist_value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind_type'(req_tuser) == REQ_QUERY)) begin
               pix_in       = req_color;
               limit_in     = sat_count;
               cnt_in       = '0;
               have_in      = 1'b0;
               best_idx_in  = '0;
               best_dist_in = '0;
               state_in     = (sat_count == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_index_in = cnt_ff[ADDR_W-1:0];
            cnt_in      = cnt_next;
            if (cnt_next == limit_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_busy && !dist_valid
                && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = INDEX_W'(best_idx_ff);
               rsp_dist_in  = best_dist_ff;
               rsp_found_in = have_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff     <= limit_in;
      cnt_ff       <= cnt_in;
      pix_ff       <= pix_in;
      rd_index_ff  <= rd_index_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
   end

   // pack response payload
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_dist_ff, rsp_idx_ff});
   assign rsp_tuser  = rsp_found_ff;

   // no read or distance work outside a query
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rd_valid_ff && !dist_busy && !dist_valid))
      else $error("palette pipeline active while idle");

   // scan address stays below the clipped count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff < limit_ff))
      else $error("scan address beyond palette count");

   // best distance never exceeds the largest possible sum
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (best_dist_ff <= MAX_DIST))
      else $error("best distance out of range");

   // an empty search answers with zero index and distance
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty search result not zero");

   // a response appears only after the search has drained
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DRAIN))
      else $error("response raised outside drain");

endmodule

// ----- tb/sv/nearest_palette_color_search_unit_tb.sv -----
// -----------------------------------------------------------------------------
// nearest_palette_color_search_unit_tb: self-checking bench for the palette search
// Loads palettes, sweeps the palette count and streams queries while both
// streams idle at random. A local search over a shadow copy of the palette
// predicts each response, and the response is checked field by field.
// -----------------------------------------------------------------------------
module nearest_palette_color_search_unit_tb
   import npcs_pkg::*;
;

   // a reduced store keeps the run short and sends some loads past its end
   localparam int DEPTH        = 256;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 290;

   // one predicted response
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
      logic               found;
   } match_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // entry_index, blue_in, green_in, red_in
   logic                   req_tuser  = 1'b0; // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // best_index, best_distance
   logic                   rsp_tuser;         // found
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data   = '0;

   // shadow state of the block
   color_type          palette_shadow [DEPTH];
   logic [COUNT_W-1:0] count_shadow = '0;
   match_type          pending_matches [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count;
   bit          pacing_on     = 1'b0;
   bit          rsp_long_hold = 1'b0;

   nearest_palette_color_search_unit #(
      .PALETTE_DEPTH (DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // search the shadow palette; the first entry at the smallest distance wins
   function automatic match_type predict_nearest(input color_type px);
      match_type   best;
      int unsigned span;
      int unsigned slot;
      int          db, dg, dr;
      int unsigned sq_sum;
      best = '0;
      span = (count_shadow > DEPTH) ? DEPTH : count_shadow;
      for (slot = 0; slot < span; slot++) begin
         db     = int'(palette_shadow[slot].blue)  - int'(px.blue);
         dg     = int'(palette_shadow[slot].green) - int'(px.green);
         dr     = int'(palette_shadow[slot].red)   - int'(px.red);
         sq_sum = db * db + dg * dg + dr * dr;
         if (!best.found || sq_sum < best.distance) begin
            best.found    = 1'b1;
            best.distance = DIST_W'(sq_sum);
            best.index    = INDEX_W'(slot);
         end
      end
      return best;
   endfunction

   function automatic color_type bgr(input int unsigned b, input int unsigned g,
                                     input int unsigned r);
      color_type c;
      c.blue  = CHAN_W'(b);
      c.green = CHAN_W'(g);
      c.red   = CHAN_W'(r);
      return c;
   endfunction

   // favor the channel extremes so that ties and large distances show up
   function automatic logic [CHAN_W-1:0] random_channel();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic color_type random_color();
      return bgr(random_channel(), random_channel(), random_channel());
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!pacing_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request from a falling edge, predict it once accepted
   task automatic send_request(input req_kind_type kind, input logic [INDEX_W-1:0] slot,
                               input color_type c);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({c.red, c.green, c.blue, slot});
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_LOAD) begin
         if (slot < DEPTH) palette_shadow[slot] = c;
      end else begin
         pending_matches = {pending_matches, predict_nearest(c)};
      end
      @(negedge clock);
   endtask

   // drop valid, drain all responses, then let a trailing load settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_palette_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      count_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // check every accepted response against the oldest prediction
   initial begin : response_check
      match_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_matches.size() == 0) begin
               $display("%0t: extra response: expected none, actual %0d/%0d/%0d",
                        $time, rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W +: DIST_W],
                        rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_matches.pop_front();
               check_field("best_index", want.index, rsp_tdata[INDEX_W-1:0]);
               check_field("best_distance", want.distance, rsp_tdata[INDEX_W +: DIST_W]);
               check_field("found", want.found, rsp_tuser);
            end
         end
      end
   end

   // pace the response side; a requested long hold is counted down here
   initial begin : response_pacing
      int unsigned hold_left;
      int unsigned gap_left;
      hold_left = 0;
      gap_left  = 0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            gap_left = pick_gap();
         end
      end
   end

   // end the run if it hangs
   initial begin : cycle_watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // empty palette: reset count first, then an explicit zero
   task automatic test_empty_palette();
      pacing_on = 1'b0;
      send_request(REQ_QUERY, '0, bgr(0, 0, 0));
      write_palette_count('0);
      send_request(REQ_QUERY, '1, bgr(255, 255, 255));
   endtask

   // few entries: largest distance, exact hit, tie to the earlier slot
   task automatic test_small_palette();
      pacing_on = 1'b1;
      send_request(REQ_LOAD, INDEX_W'(0), bgr(0, 0, 0));
      send_request(REQ_LOAD, INDEX_W'(1), bgr(255, 255, 255));
      send_request(REQ_LOAD, INDEX_W'(2), bgr(10, 200, 30));
      send_request(REQ_LOAD, INDEX_W'(3), bgr(255, 0, 128));
      send_request(REQ_LOAD, INDEX_W'(4), bgr(10, 200, 30));
      send_request(REQ_LOAD, INDEX_W'(5), bgr(0, 255, 0));
      write_palette_count(COUNT_W'(1));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(255, 255, 255));
      write_palette_count(COUNT_W'(6));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(255, 0, 128));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(10, 200, 30));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(128, 128, 128));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(0, 0, 0));
      send_request(REQ_QUERY, INDEX_W'(0), bgr(1, 250, 2));
   endtask

   // fill every slot, then search full depth and a saturated count
   task automatic test_full_palette();
      int unsigned slot;
      pacing_on = 1'b1;
      for (slot = 0; slot < DEPTH; slot++)
         send_request(REQ_LOAD, INDEX_W'(slot), random_color());
      send_request(REQ_LOAD, INDEX_W'(DEPTH - 1), bgr(1, 254, 127));
      write_palette_count(COUNT_W'(DEPTH));
      send_request(REQ_QUERY, '0, bgr(1, 254, 127));
      send_request(REQ_QUERY, '1, random_color());
      write_palette_count('1);
      send_request(REQ_QUERY, '0, random_color());
      send_request(REQ_QUERY, '1, bgr(255, 255, 255));
      write_palette_count(COUNT_W'(DEPTH - 1));
      send_request(REQ_QUERY, '0, bgr(1, 254, 127));
   endtask

   // hold responses off long enough that the request side backs up
   task automatic test_response_backpressure();
      int unsigned n;
      write_palette_count(COUNT_W'(4));
      pacing_on     = 1'b0;
      rsp_long_hold = 1'b1;
      for (n = 0; n < 16; n++) begin
         if (n % 4 == 3)
            send_request(REQ_LOAD, INDEX_W'($urandom_range(16, DEPTH - 1)), random_color());
         else
            send_request(REQ_QUERY, INDEX_W'($urandom), random_color());
      end
   endtask

   // phases of random loads and queries, each under a fresh palette count
   task automatic test_random_traffic();
      int unsigned        sent;
      int unsigned        burst;
      int unsigned        roll;
      int unsigned        k;
      int unsigned        span;
      logic [COUNT_W-1:0] count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)       count = '0;
         else if (roll < 78) count = COUNT_W'($urandom_range(1, 48));
         else if (roll < 92) count = COUNT_W'($urandom_range(49, 400));
         else                count = COUNT_W'($urandom_range(900, 2047));
         burst = (count > 400) ? 3 : $urandom_range(10, 40);
         span  = (count > DEPTH) ? DEPTH : count;
         write_palette_count(count);
         pacing_on = ($urandom_range(0, 3) != 0);
         for (k = 0; k < burst; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 18 && span != 0)
               send_request(REQ_LOAD, INDEX_W'($urandom_range(0, span - 1)), random_color());
            else if (roll < 35)
               send_request(REQ_LOAD, INDEX_W'($urandom), random_color());
            else
               send_request(REQ_QUERY, INDEX_W'($urandom), random_color());
         end
         sent += burst;
      end
   endtask

   initial begin : test_sequence
      int unsigned tail;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_palette();
      test_small_palette();
      test_full_palette();
      test_response_backpressure();
      test_random_traffic();
      wait_idle();
      tail = ((count_shadow > DEPTH) ? DEPTH : count_shadow) + 16;
      repeat (tail) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
